[design/utt_pkg.sv]
// Shared types and constants of the UTF-8 transcoder.
`default_nettype none

package utt_pkg;

   localparam int UNIT_W   = 21;
   localparam int COUNT_W  = 16;
   localparam int MAX_UNITS = 4;
   localparam int NUNITS_W = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DEST_FORMAT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_UNITS   = 1'd1;

   localparam logic [1:0] FMT_UTF8  = 2'd0;
   localparam logic [1:0] FMT_UTF16 = 2'd1;

   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_REJECTED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   typedef struct packed {
      logic [MAX_UNITS-1:0][UNIT_W-1:0] units;
      logic [NUNITS_W-1:0]              n_units;
      logic                             closes;
      logic [1:0]                       status;
      logic [COUNT_W-1:0]               base_count;
   } entry_type;

endpackage

`default_nettype wire

[design/utt_queue.sv]
// Small register queue of decoded entries between the front and back parts.
`default_nettype none

module utt_queue
   import utt_pkg::*;
#(
   parameter int Depth = 4
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      wr_en,
   input  wire entry_type wr_data,
   output logic           q_full,
   input  wire logic      rd_en,
   output entry_type      rd_data,
   output logic           q_valid
);

   localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CNT_W = $clog2(Depth + 1);

   entry_type            store_ff [Depth];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(Depth - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = wr_en ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = rd_en ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign q_full  = (count_ff == CNT_W'(Depth));
   assign q_valid = (count_ff != '0);
   assign rd_data = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

[design/utt_front.sv]
// Front part: configuration, byte assembly, code point checks and encoding.
`default_nettype none

module utt_front
   import utt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  accept,
   input  wire logic [7:0]            in_byte,
   input  wire logic                  string_end,
   output logic                       push_en,
   output entry_type                  push_data
);

   logic [1:0]          fmt_ff;
   logic [COUNT_W-1:0]  max_ff;
   logic [UNIT_W-1:0]   partial_ff, partial_in;
   logic [1:0]          needed_ff, needed_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                halted_ff, halted_in;
   logic [1:0]          reason_ff, reason_in;

   logic                active;
   logic                have_point;
   logic [UNIT_W-1:0]   cp;
   logic                rejected;
   logic                mark;
   logic [MAX_UNITS-1:0][UNIT_W-1:0] units;
   logic [NUNITS_W-1:0] n_enc;
   logic [NUNITS_W-1:0] n_out;
   logic [UNIT_W-1:0]   sup;
   logic [COUNT_W:0]    need_total;

   always_comb begin
      active     = !halted_ff && (max_ff != '0);
      have_point = 1'b0;
      cp         = '0;
      partial_in = partial_ff;
      needed_in  = needed_ff;
      if (active) begin
         if (needed_ff != 2'd0 && in_byte[7:6] == 2'b10) begin
            partial_in = {partial_ff[UNIT_W-7:0], in_byte[5:0]};
            needed_in  = needed_ff - 2'd1;
            if (needed_ff == 2'd1) begin
               have_point = 1'b1;
               cp         = {partial_ff[UNIT_W-7:0], in_byte[5:0]};
            end
         end else begin
            needed_in = 2'd0;
            priority if (!in_byte[7]) begin
               have_point = 1'b1;
               cp         = {13'd0, in_byte};
            end else if (in_byte[7:5] == 3'b110) begin
               partial_in = {16'd0, in_byte[4:0]};
               needed_in  = 2'd1;
            end else if (in_byte[7:4] == 4'b1110) begin
               partial_in = {17'd0, in_byte[3:0]};
               needed_in  = 2'd2;
            end else if (in_byte[7:3] == 5'b11110) begin
               partial_in = {18'd0, in_byte[2:0]};
               needed_in  = 2'd3;
            end else begin
               needed_in = 2'd0;
            end
         end
         if (have_point) begin
            partial_in = '0;
         end
      end
   end

   always_comb begin
      mark = (cp >= 21'h000300 && cp <= 21'h00036F) ||
             (cp >= 21'h001DC0 && cp <= 21'h001DFF) ||
             (cp >= 21'h0020D0 && cp <= 21'h0020FF) ||
             (cp >= 21'h00FE20 && cp <= 21'h00FE2F);
      rejected = (cp >= 21'h00D800 && cp <= 21'h00DFFF) ||
                 (cp >= 21'h00FDD0 && cp <= 21'h00FDEF) ||
                 (cp[15:1] == 15'h7FFF) ||
                 (cp > 21'h10FFFF) ||
                 (count_ff == '0 && mark);
   end

   always_comb begin
      units = '0;
      sup   = cp - 21'h010000;
      n_enc = 3'd1;
      if (fmt_ff == FMT_UTF8) begin
         priority if (cp <= 21'h00007F) begin
            units[0] = cp;
         end else if (cp <= 21'h0007FF) begin
            units[0] = {13'd0, 3'b110, cp[10:6]};
            units[1] = {13'd0, 2'b10, cp[5:0]};
            n_enc    = 3'd2;
         end else if (cp <= 21'h00FFFF) begin
            units[0] = {13'd0, 4'b1110, cp[15:12]};
            units[1] = {13'd0, 2'b10, cp[11:6]};
            units[2] = {13'd0, 2'b10, cp[5:0]};
            n_enc    = 3'd3;
         end else begin
            units[0] = {13'd0, 5'b11110, cp[20:18]};
            units[1] = {13'd0, 2'b10, cp[17:12]};
            units[2] = {13'd0, 2'b10, cp[11:6]};
            units[3] = {13'd0, 2'b10, cp[5:0]};
            n_enc    = 3'd4;
         end
      end else if (fmt_ff == FMT_UTF16 && cp > 21'h00FFFF) begin
         units[0] = {5'd0, 6'b110110, sup[19:10]};
         units[1] = {5'd0, 6'b110111, sup[9:0]};
         n_enc    = 3'd2;
      end else begin
         units[0] = cp;
      end
      need_total = {1'b0, count_ff} + {{(COUNT_W-2){1'b0}}, n_enc};
   end

   always_comb begin
      n_out     = '0;
      halted_in = halted_ff;
      reason_in = reason_ff;
      if (have_point) begin
         if (rejected) begin
            halted_in = 1'b1;
            reason_in = STATUS_REJECTED;
         end else if (need_total > {1'b0, max_ff}) begin
            halted_in = 1'b1;
            reason_in = STATUS_FULL;
         end else begin
            n_out = n_enc;
         end
      end
      count_in = count_ff + {{(COUNT_W-NUNITS_W){1'b0}}, n_out};

      push_data.units      = units;
      push_data.n_units    = n_out;
      push_data.closes     = string_end;
      push_data.status     = reason_in;
      push_data.base_count = count_ff;
      push_en              = accept && (n_out != '0 || string_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff     <= FMT_UTF16;
         max_ff     <= 16'hFFFF;
         partial_ff <= '0;
         needed_ff  <= '0;
         count_ff   <= '0;
         halted_ff  <= 1'b0;
         reason_ff  <= STATUS_DONE;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_DEST_FORMAT: fmt_ff <= csr_wdata[1:0];
               CSR_MAX_UNITS:   max_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            if (string_end) begin
               partial_ff <= '0;
               needed_ff  <= '0;
               count_ff   <= '0;
               halted_ff  <= 1'b0;
               reason_ff  <= STATUS_DONE;
            end else begin
               partial_ff <= partial_in;
               needed_ff  <= needed_in;
               count_ff   <= count_in;
               halted_ff  <= halted_in;
               reason_ff  <= reason_in;
            end
         end
      end
   end

endmodule

`default_nettype wire

[design/utt_back.sv]
// Back part: walks each queued entry and issues one result per cycle while results are popped.
`default_nettype none

module utt_back
   import utt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire entry_type           head,
   output logic                     q_pop,
   output logic                     empty,
   input  wire logic                pop,
   output logic [UNIT_W-1:0]        rsp_code_unit,
   output logic                     rsp_unit_present,
   output logic                     rsp_last_of_run,
   output logic                     rsp_string_done,
   output logic [1:0]               rsp_stop_status,
   output logic [COUNT_W-1:0]       rsp_units_written
);

   logic [1:0]          idx_ff, idx_in;
   logic                valid_ff, valid_in;
   logic [UNIT_W-1:0]   code_ff;
   logic                present_ff, last_ff, done_ff;
   logic [1:0]          status_ff;
   logic [COUNT_W-1:0]  written_ff;

   logic                load;
   logic                present;
   logic                last;

   always_comb begin
      load    = q_valid && (!valid_ff || pop);
      present = (head.n_units != '0);
      last    = !present || ({1'b0, idx_ff} == head.n_units - NUNITS_W'(1));
      q_pop   = load && last;
      idx_in  = idx_ff;
      if (load) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
      valid_in = load || (valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff    <= present ? head.units[idx_ff] : '0;
         present_ff <= present;
         last_ff    <= last;
         done_ff    <= last && head.closes;
         status_ff  <= (last && head.closes) ? head.status : STATUS_DONE;
         written_ff <= head.base_count + {{(COUNT_W-2){1'b0}}, idx_ff}
                       + {{(COUNT_W-1){1'b0}}, present};
      end
   end

   assign empty             = !valid_ff;
   assign rsp_code_unit     = code_ff;
   assign rsp_unit_present  = present_ff;
   assign rsp_last_of_run   = last_ff;
   assign rsp_string_done   = done_ff;
   assign rsp_stop_status   = status_ff;
   assign rsp_units_written = written_ff;

endmodule

`default_nettype wire

[design/utf8_to_utf16_utf32_transcoder.sv]
// Top level of the UTF-8 to UTF-8/UTF-16/UTF-32 transcoder.
//
//   Channel  Handshake       Payload
//   req      push / full     req_in_byte, req_string_end
//   rsp      empty / pop     rsp_code_unit, unit_present, last_of_run,
//                            string_done, stop_status, units_written
//   csr      csr_we          csr_index, csr_wdata
//
// One input byte is taken per cycle while the entry queue has room; the
// front decodes and checks it in the cycle it is accepted.
// The back issues one result per cycle while results are popped, so a byte that yields
// four UTF-8 units takes four output results; the queue absorbs the difference.
// A full queue stalls the input; a held result stalls only the back part.
// Reset is synchronous and clears all string state and restores defaults.
`default_nettype none

module utf8_to_utf16_utf32_transcoder
   import utt_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire logic [7:0]            req_in_byte,
   input  wire logic                  req_string_end,
   output logic                       empty,
   input  wire logic                  pop,
   output logic [UNIT_W-1:0]          rsp_code_unit,
   output logic                       rsp_unit_present,
   output logic                       rsp_last_of_run,
   output logic                       rsp_string_done,
   output logic [1:0]                 rsp_stop_status,
   output logic [COUNT_W-1:0]         rsp_units_written,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic      accept;
   logic      q_wr;
   logic      q_rd;
   logic      q_full;
   logic      q_valid;
   entry_type wr_entry;
   entry_type head;

   assign full   = q_full;
   assign accept = push && !q_full;

   utt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .string_end (req_string_end),
      .push_en    (q_wr),
      .push_data  (wr_entry)
   );

   utt_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr),
      .wr_data (wr_entry),
      .q_full  (q_full),
      .rd_en   (q_rd),
      .rd_data (head),
      .q_valid (q_valid)
   );

   utt_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .head              (head),
      .q_pop             (q_rd),
      .empty             (empty),
      .pop               (pop),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_unit_present  (rsp_unit_present),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_string_done   (rsp_string_done),
      .rsp_stop_status   (rsp_stop_status),
      .rsp_units_written (rsp_units_written)
   );

endmodule

`default_nettype wire

[dv/utf8_to_utf16_utf32_transcoder_tb.sv]
// Self-checking testbench of the UTF-8 transcoder: directed strings, random traffic, backpressure.
module utf8_to_utf16_utf32_transcoder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import utt_pkg::*;

   localparam logic [1:0] FMT_UTF32 = 2'd2;
   localparam logic [1:0] FMT_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic [UNIT_W-1:0]  code_unit;
      logic               present;
      logic               last_run;
      logic               done;
      logic [1:0]         status;
      logic [COUNT_W-1:0] written;
   } result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [7:0] req_in_byte = '0;
   logic req_string_end = 1'b0;
   logic empty;
   logic pop = 1'b0;
   logic [UNIT_W-1:0] rsp_code_unit;
   logic rsp_unit_present;
   logic rsp_last_of_run;
   logic rsp_string_done;
   logic [1:0] rsp_stop_status;
   logic [COUNT_W-1:0] rsp_units_written;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predicted transcoder state and register copies.
   logic [1:0] out_format = FMT_UTF16;
   logic [15:0] cap_units = 16'hFFFF;
   logic [20:0] part_point = '0;
   logic [1:0] need_bytes = '0;
   logic [15:0] text_units = '0;
   logic text_halted = 1'b0;
   logic [1:0] stop_reason = STATUS_DONE;

   result_t expected_units[$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   utf8_to_utf16_utf32_transcoder dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_in_byte(req_in_byte),
      .req_string_end(req_string_end),
      .empty(empty),
      .pop(pop),
      .rsp_code_unit(rsp_code_unit),
      .rsp_unit_present(rsp_unit_present),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_string_done(rsp_string_done),
      .rsp_stop_status(rsp_stop_status),
      .rsp_units_written(rsp_units_written),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int utf8_len(input logic [20:0] cp);
      return (cp <= 21'h7F) ? 1 : (cp <= 21'h7FF) ? 2 : (cp <= 21'hFFFF) ? 3 : 4;
   endfunction

   // Byte 0 is the lead; a length above the natural one gives an overlong form.
   function automatic logic [3:0][7:0] utf8_form(input logic [20:0] cp, input int len);
      logic [3:0][7:0] seq;
      int k;
      seq = '0;
      case (len)
         1: seq[0] = {1'b0, cp[6:0]};
         2: seq[0] = {3'b110, cp[10:6]};
         3: seq[0] = {4'b1110, cp[15:12]};
         default: seq[0] = {5'b11110, cp[20:18]};
      endcase
      for (k = 1; k < len; k++) seq[k] = {2'b10, cp[6 * (len - 1 - k) +: 6]};
      return seq;
   endfunction

   function automatic bit is_refused(input logic [20:0] cp);
      bit mark;
      mark = (cp >= 21'h0300 && cp <= 21'h036F) || (cp >= 21'h1DC0 && cp <= 21'h1DFF) ||
             (cp >= 21'h20D0 && cp <= 21'h20FF) || (cp >= 21'hFE20 && cp <= 21'hFE2F);
      return (cp >= 21'hD800 && cp <= 21'hDFFF) || (cp >= 21'hFDD0 && cp <= 21'hFDEF) ||
             (cp[15:1] == 15'h7FFF) || (cp > 21'h10FFFF) || (text_units == 0 && mark);
   endfunction

   function automatic void transcode_byte(input logic [7:0] b, input logic last_byte);
      logic [20:0] cp;
      logic [19:0] v;
      logic [3:0][UNIT_W-1:0] u;
      logic [3:0][7:0] seq;
      result_t r;
      bit have;
      int n;
      int i;
      have = 1'b0;
      cp = '0;
      u = '0;
      n = 0;
      if (!text_halted && cap_units != 0) begin
         if (need_bytes != 0 && b[7:6] == 2'b10) begin
            part_point = {part_point[14:0], b[5:0]};
            need_bytes--;
            if (need_bytes == 0) begin
               cp = part_point;
               have = 1'b1;
            end
         end else begin
            need_bytes = 0;
            if (!b[7]) begin
               cp = {13'd0, b};
               have = 1'b1;
            end else if (b[7:5] == 3'b110) begin
               part_point = {16'd0, b[4:0]};
               need_bytes = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
               part_point = {17'd0, b[3:0]};
               need_bytes = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
               part_point = {18'd0, b[2:0]};
               need_bytes = 2'd3;
            end
         end
         if (have) begin
            part_point = '0;
            if (is_refused(cp)) begin
               text_halted = 1'b1;
               stop_reason = STATUS_REJECTED;
            end else begin
               case (out_format)
                  FMT_UTF8: begin
                     n = utf8_len(cp);
                     seq = utf8_form(cp, n);
                     for (i = 0; i < 4; i++) u[i] = {13'd0, seq[i]};
                  end
                  FMT_UTF16: begin
                     if (cp > 21'hFFFF) begin
                        v = 20'(cp - 21'h10000);
                        u[0] = 21'h00D800 + {11'd0, v[19:10]};
                        u[1] = 21'h00DC00 + {11'd0, v[9:0]};
                        n = 2;
                     end else begin
                        u[0] = cp;
                        n = 1;
                     end
                  end
                  default: begin
                     u[0] = cp;
                     n = 1;
                  end
               endcase
               if (int'(text_units) + n > int'(cap_units)) begin
                  text_halted = 1'b1;
                  stop_reason = STATUS_FULL;
                  n = 0;
               end
            end
         end
      end
      for (i = 0; i < n; i++) begin
         text_units++;
         r.code_unit = u[i];
         r.present = 1'b1;
         r.last_run = (i == n - 1);
         r.done = (i == n - 1) && last_byte;
         r.status = r.done ? stop_reason : STATUS_DONE;
         r.written = text_units;
         expected_units.push_back(r);
      end
      if (last_byte) begin
         if (n == 0) begin
            r.code_unit = '0;
            r.present = 1'b0;
            r.last_run = 1'b1;
            r.done = 1'b1;
            r.status = stop_reason;
            r.written = text_units;
            expected_units.push_back(r);
         end
         part_point = '0;
         need_bytes = '0;
         text_units = '0;
         text_halted = 1'b0;
         stop_reason = STATUS_DONE;
      end
   endfunction

   function automatic logic [20:0] random_point();
      case ($urandom_range(11))
         0, 1: return 21'($urandom_range(32'h7F));
         2: return 21'($urandom_range(32'h7FF, 32'h80));
         3: return 21'($urandom_range(32'hFFFF, 32'h800));
         4: return 21'($urandom_range(32'h10FFFF, 32'h10000));
         5: return 21'($urandom_range(32'hDFFF, 32'hD800));
         6: return 21'($urandom_range(32'hFDEF, 32'hFDD0));
         7: return 21'(($urandom_range(16) << 16) | 32'hFFFE | $urandom_range(1));
         8: case ($urandom_range(3))
               0: return 21'($urandom_range(32'h036F, 32'h0300));
               1: return 21'($urandom_range(32'h1DFF, 32'h1DC0));
               2: return 21'($urandom_range(32'h20FF, 32'h20D0));
               default: return 21'($urandom_range(32'hFE2F, 32'hFE20));
            endcase
         9: return 21'($urandom_range(32'h1FFFFF, 32'h110000));
         default: return 21'($urandom_range(32'h7FF));
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last_byte);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_in_byte <= b;
      req_string_end <= last_byte;
      do @(posedge clock); while (full);
      transcode_byte(b, last_byte);
   endtask

   task automatic settle();
      push <= 1'b0;
      while (expected_units.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DEST_FORMAT) out_format = 2'(value);
      else cap_units = 16'(value);
      @(posedge clock);
   endtask

   task automatic test_mixed_sequences();
      settle();
      write_reg(CSR_DEST_FORMAT, FMT_UTF8);
      send_idle_pct = 0;
      stall_pct = 0;
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0);
      send_byte(8'h98, 1'b0); send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hC3, 1'b0); send_byte(8'h41, 1'b0);
      send_byte(8'hC0, 1'b0); send_byte(8'h81, 1'b0);
      send_byte(8'hCC, 1'b0); send_byte(8'h80, 1'b0);
      send_byte(8'hE2, 1'b1);
   endtask

   task automatic test_rejections();
      settle();
      write_reg(CSR_DEST_FORMAT, FMT_UTF16);
      send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0);
      send_byte(8'h80, 1'b0); send_byte(8'h41, 1'b1);
      send_byte(8'hCC, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h41, 1'b1);
      send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBE, 1'b1);
   endtask

   task automatic test_capacity();
      settle();
      write_reg(CSR_DEST_FORMAT, FMT_UTF8);
      write_reg(CSR_MAX_UNITS, 2);
      send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0); send_byte(8'h41, 1'b1);
      settle();
      write_reg(CSR_MAX_UNITS, 0);
      send_byte(8'h41, 1'b0); send_byte(8'h42, 1'b1);
   endtask

   task automatic test_spare_format();
      settle();
      write_reg(CSR_DEST_FORMAT, FMT_SPARE);
      write_reg(CSR_MAX_UNITS, 16'hFFFF);
      send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0);
      send_byte(8'h98, 1'b0); send_byte(8'h80, 1'b1);
   endtask

   task automatic test_format_change_mid_string();
      settle();
      write_reg(CSR_DEST_FORMAT, FMT_UTF16);
      send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0);
      settle();
      write_reg(CSR_DEST_FORMAT, FMT_UTF8);
      send_byte(8'hAC, 1'b1);
   endtask

   task automatic test_random_traffic(input logic [1:0] fmt, input int cap, input int send_pct,
                                      input int recv_pct, input int n_bytes);
      logic [20:0] cp;
      logic [3:0][7:0] seq;
      int len;
      int keep;
      int sent;
      int k;
      settle();
      write_reg(CSR_DEST_FORMAT, fmt);
      write_reg(CSR_MAX_UNITS, cap);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
      sent = 0;
      while (sent < n_bytes) begin
         if ($urandom_range(9) == 0) begin
            send_byte(8'($urandom_range(255)), $urandom_range(5) == 0);
            sent++;
         end else begin
            cp = random_point();
            len = utf8_len(cp);
            if (len < 4 && $urandom_range(7) == 0) len = int'($urandom_range(4, len + 1));
            keep = (len > 1 && $urandom_range(9) == 0) ? int'($urandom_range(len - 1, 1)) : len;
            seq = utf8_form(cp, len);
            for (k = 0; k < keep; k++)
               send_byte(seq[k], (k == keep - 1) && ($urandom_range(5) == 0));
            sent += keep;
         end
      end
   endtask

   task automatic test_backpressure();
      int k;
      settle();
      write_reg(CSR_DEST_FORMAT, FMT_UTF8);
      write_reg(CSR_MAX_UNITS, 16'hFFFF);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_requests++;
      for (k = 0; k < 6; k++) begin
         send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0);
         send_byte(8'h98, 1'b0); send_byte(8'(8'h80 + k), 1'b0);
      end
      send_byte(8'h41, 1'b1);
   endtask

   task automatic check_field(input string name, input logic [UNIT_W-1:0] want,
                              input logic [UNIT_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         hold_left <= 0;
         holds_served <= 0;
      end else if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         pop <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      result_t want;
      if (!reset && pop && !empty) begin
         if (expected_units.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected transaction, expected none, actual code_unit %0h",
                     $time, rsp_code_unit);
         end else begin
            want = expected_units.pop_front();
            check_field("code_unit", want.code_unit, rsp_code_unit);
            check_field("unit_present", 21'(want.present), 21'(rsp_unit_present));
            check_field("last_of_run", 21'(want.last_run), 21'(rsp_last_of_run));
            check_field("string_done", 21'(want.done), 21'(rsp_string_done));
            check_field("stop_status", 21'(want.status), 21'(rsp_stop_status));
            check_field("units_written", 21'(want.written), 21'(rsp_units_written));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_mixed_sequences();
      test_rejections();
      test_capacity();
      test_spare_format();
      test_format_change_mid_string();
      test_random_traffic(FMT_UTF8, 16'hFFFF, 0, 0, 10);
      test_random_traffic(FMT_UTF16, 6, 86, 0, 10);
      test_random_traffic(FMT_UTF32, 16'hFFFF, 0, 86, 10);
      test_random_traffic(FMT_UTF8, 9, 16, 16, 10);
      test_random_traffic(FMT_UTF16, 1, 16, 16, 10);
      test_backpressure();
      settle();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[filelist.f]
design/utt_pkg.sv
design/utt_queue.sv
design/utt_front.sv
design/utt_back.sv
design/utf8_to_utf16_utf32_transcoder.sv
dv/utf8_to_utf16_utf32_transcoder_tb.sv
